>>> hdl/c8iu_pkg.sv
// ----------------------------------------------------------------------------
// c8iu_pkg
// Shared codes for the CHIP-8 instruction unit.
// ----------------------------------------------------------------------------
`default_nettype none
package c8iu_pkg;
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_STEP    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

    localparam logic [11:0] ENTRY_RESET = 12'd512;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [11:0] pc;
        logic [1:0]  fault;
        logic        clear_screen;
        logic        sound_active;
        logic        waiting_key;
    } result_t;
endpackage
`default_nettype wire

>>> hdl/chip8_instruction_unit_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_unit_core
// CHIP-8 execution core: byte memory, V registers, index, return stack, timers.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    command, address, write_data, keys, random
// m_        out        m_valid/m_ready    read_data, pc, fault, cls, sound, waiting
// cfg       in         cfg_valid/ready    entry address (12 bits)
//
// A read issues one memory read; a step reads two opcode bytes through the
// single memory port, then executes. Fx33 subtracts repeatedly for hundreds
// and tens and writes each digit, Fx55 stores V0..Vx a byte at a time and Fx65
// loads them with an issue and a capture per byte. s_ready returns in the
// cycle after the result transaction. Reset is synchronous; memory and return
// stack contents are undefined until written.
`default_nettype none
module chip8_instruction_unit_core #(
    parameter int MEM_DEPTH   = 4096,
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [11:0] s_address,
    input  wire logic [7:0]  s_write_data,
    input  wire logic [15:0] s_keys_down,
    input  wire logic [7:0]  s_random_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic [11:0]      m_pc,
    output logic [1:0]       m_fault,
    output logic             m_clear_screen,
    output logic             m_sound_active,
    output logic             m_waiting_key,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);
    import c8iu_pkg::*;

    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SDW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MEMRD = 4'd1;  // memory read issued
    localparam logic [3:0] ST_FHI   = 4'd2;  // high opcode byte issued
    localparam logic [3:0] ST_FLO   = 4'd3;  // low opcode byte issued
    localparam logic [3:0] ST_FLO2  = 4'd4;  // low byte arriving
    localparam logic [3:0] ST_EXEC  = 4'd5;
    localparam logic [3:0] ST_BCD   = 4'd6;
    localparam logic [3:0] ST_STORE = 4'd7;
    localparam logic [3:0] ST_LOAD  = 4'd8;
    localparam logic [3:0] ST_LOADW = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]  state_reg;
    logic [11:0] entry_reg;
    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  mem_q_reg;
    logic [7:0]  v_reg [16];
    logic [11:0] ret_mem [STACK_DEPTH];
    logic [11:0] ret_q_reg;
    logic [15:0] i_reg;
    logic [11:0] pc_reg, newpc_reg;
    logic [SDW-1:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [15:0] op_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  rnd_reg;
    logic [15:0] keys_reg;
    logic [3:0]  cnt_reg;        // byte counter for block moves and BCD
    logic [15:0] ptr_reg;        // I-based address pointer
    logic        mem_in_range_reg;
    logic [7:0]  bcd_reg;        // remaining value during BCD
    logic [7:0]  digit_reg;      // subtractions counted for the current digit
    result_t     res_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = (state_reg == ST_OUT);
    assign m_read_data       = res_reg.read_data;
    assign m_pc              = res_reg.pc;
    assign m_fault           = res_reg.fault;
    assign m_clear_screen    = res_reg.clear_screen;
    assign m_sound_active    = res_reg.sound_active;
    assign m_waiting_key     = res_reg.waiting_key;

    // opcode fields
    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_kk, vx, vy;
    logic [11:0] op_nnn;
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_kk  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];
    assign vx     = v_reg[op_x];
    assign vy     = v_reg[op_y];

    // single memory port control
    logic        mem_we;
    logic [15:0] mem_a;
    logic [7:0]  mem_wd;
    logic        mem_ok;
    assign mem_ok = (mem_a < 16'(MEM_DEPTH));

    // shared 9-bit adder
    logic [8:0] alu_sum;
    logic [7:0] alu_a, alu_b;
    logic       alu_sub;
    assign alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});

    // lowest pressed key
    logic [3:0] low_key;
    always_comb begin
        low_key = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) low_key = 4'(k);
        end
    end

    logic key_dn;
    assign key_dn = (vx < 8'd16) && keys_reg[vx[3:0]];

    always_comb begin
        mem_we = 1'b0;
        mem_a  = {4'd0, pc_reg};
        mem_wd = 8'd0;
        case (state_reg)
            ST_IDLE: begin
                mem_a  = {4'd0, s_address};
                mem_we = s_valid && (s_command == CMD_WRITE);
                mem_wd = s_write_data;
            end
            ST_FLO:   mem_a = {4'd0, pc_reg + 12'd1};
            ST_BCD: begin
                // a digit is written once its subtractions are done
                mem_a  = ptr_reg;
                mem_we = (cnt_reg == 4'd2) || alu_sum[8];
                mem_wd = (cnt_reg == 4'd2) ? bcd_reg : digit_reg;
            end
            ST_STORE: begin
                mem_a  = ptr_reg;
                mem_we = 1'b1;
                mem_wd = v_reg[cnt_reg];
            end
            ST_LOAD:  mem_a = ptr_reg;
            default:  mem_a = {4'd0, pc_reg};
        endcase
    end

    // BCD digit via repeated subtraction on the shared adder
    logic [7:0] bcd_sub;
    always_comb begin
        alu_a   = vx;
        alu_b   = vy;
        alu_sub = 1'b0;
        bcd_sub = 8'd0;
        if (state_reg == ST_BCD) begin
            bcd_sub = (cnt_reg == 4'd0) ? 8'd100 : 8'd10;
            alu_a   = bcd_reg;
            alu_b   = bcd_sub;
            alu_sub = 1'b1;
        end else if (op_reg[15:12] == 4'h7) begin
            alu_b = op_kk;
        end else if (op_reg[15:12] == 4'h8 && op_n == 4'h5) begin
            alu_sub = 1'b1;
        end else if (op_reg[15:12] == 4'h8 && op_n == 4'h7) begin
            alu_a   = vy;
            alu_b   = vx;
            alu_sub = 1'b1;
        end
    end

    // memory array
    always_ff @(posedge aclk) begin
        if (mem_we && mem_ok) mem[mem_a[MAW-1:0]] <= mem_wd;
        mem_q_reg        <= mem[mem_a[MAW-1:0]];
        mem_in_range_reg <= mem_ok;
        ret_q_reg        <= ret_mem[SAW'(sp_reg - SDW'(1))];
        if (state_reg == ST_EXEC && op_reg[15:12] == 4'h2
            && sp_reg < SDW'(STACK_DEPTH))
            ret_mem[sp_reg[SAW-1:0]] <= pc_reg + 12'd2;
    end

    logic [7:0] mem_rd;
    assign mem_rd = mem_in_range_reg ? mem_q_reg : 8'd0;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            entry_reg <= ENTRY_RESET;
            pc_reg    <= ENTRY_RESET;
            i_reg     <= 16'd0;
            sp_reg    <= '0;
            dt_reg    <= 8'd0;
            st_reg    <= 8'd0;
            for (int r = 0; r < 16; r++) v_reg[r] <= 8'd0;
        end else begin
            if (cfg_valid) entry_reg <= cfg_data;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_command;
                        keys_reg  <= s_keys_down;
                        rnd_reg   <= s_random_byte;
                        res_reg   <= '0;
                        case (s_command)
                            CMD_READ:    state_reg <= ST_MEMRD;
                            CMD_STEP:    state_reg <= ST_FHI;
                            CMD_RESTART: begin
                                pc_reg    <= entry_reg;
                                state_reg <= ST_FIN;
                            end
                            default:     state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_MEMRD: begin
                    res_reg.read_data <= mem_rd;
                    state_reg         <= ST_FIN;
                end
                ST_FHI: begin
                    state_reg <= ST_FLO;
                end
                ST_FLO: begin
                    op_reg[15:8] <= mem_rd;
                    state_reg    <= ST_FLO2;
                end
                ST_FLO2: begin
                    op_reg[7:0] <= mem_rd;
                    state_reg   <= ST_EXEC;
                end
                ST_EXEC: begin
                    newpc_reg <= pc_reg + 12'd2;
                    state_reg <= ST_FIN;
                    cnt_reg   <= 4'd0;
                    ptr_reg   <= i_reg;
                    case (op_reg[15:12])
                        4'h0: begin
                            if (op_reg == 16'h00E0) res_reg.clear_screen <= 1'b1;
                            else if (op_reg == 16'h00EE) begin
                                if (sp_reg == '0) res_reg.fault <= FAULT_UNDERFLOW;
                                else begin
                                    sp_reg    <= sp_reg - SDW'(1);
                                    newpc_reg <= ret_q_reg;
                                end
                            end
                        end
                        4'h1: newpc_reg <= op_nnn;
                        4'h2: begin
                            if (sp_reg >= SDW'(STACK_DEPTH))
                                res_reg.fault <= FAULT_OVERFLOW;
                            else begin
                                sp_reg    <= sp_reg + SDW'(1);
                                newpc_reg <= op_nnn;
                            end
                        end
                        4'h3: if (vx == op_kk) newpc_reg <= pc_reg + 12'd4;
                        4'h4: if (vx != op_kk) newpc_reg <= pc_reg + 12'd4;
                        4'h5: if (op_n == 4'd0 && vx == vy) newpc_reg <= pc_reg + 12'd4;
                        4'h6: v_reg[op_x] <= op_kk;
                        4'h7: v_reg[op_x] <= alu_sum[7:0];
                        4'h8: begin
                            case (op_n)
                                4'h0: v_reg[op_x] <= vy;
                                4'h1: v_reg[op_x] <= vx | vy;
                                4'h2: v_reg[op_x] <= vx & vy;
                                4'h3: v_reg[op_x] <= vx ^ vy;
                                4'h4: begin
                                    v_reg[op_x] <= alu_sum[7:0];
                                    v_reg[15]   <= {7'd0, alu_sum[8]};
                                end
                                4'h5: begin
                                    v_reg[op_x] <= alu_sum[7:0];
                                    v_reg[15]   <= {7'd0, vx > vy};
                                end
                                4'h6: begin
                                    v_reg[op_x] <= {1'b0, vx[7:1]};
                                    v_reg[15]   <= {7'd0, vx[0]};
                                end
                                4'h7: begin
                                    v_reg[op_x] <= alu_sum[7:0];
                                    v_reg[15]   <= {7'd0, vy > vx};
                                end
                                4'hE: begin
                                    v_reg[op_x] <= {vx[6:0], 1'b0};
                                    v_reg[15]   <= {7'd0, vx[7]};
                                end
                                default: ;
                            endcase
                        end
                        4'h9: if (op_n == 4'd0 && vx != vy) newpc_reg <= pc_reg + 12'd4;
                        4'hA: i_reg <= {4'd0, op_nnn};
                        4'hB: newpc_reg <= op_nnn + {4'd0, v_reg[0]};
                        4'hC: v_reg[op_x] <= rnd_reg & op_kk;
                        4'hE: begin
                            if (op_kk == 8'h9E && key_dn) newpc_reg <= pc_reg + 12'd4;
                            else if (op_kk == 8'hA1 && !key_dn)
                                newpc_reg <= pc_reg + 12'd4;
                        end
                        4'hF: begin
                            case (op_kk)
                                8'h07: v_reg[op_x] <= dt_reg;
                                8'h0A: begin
                                    if (keys_reg == 16'd0) begin
                                        res_reg.waiting_key <= 1'b1;
                                        newpc_reg           <= pc_reg;
                                    end else v_reg[op_x] <= {4'd0, low_key};
                                end
                                8'h15: dt_reg <= vx;
                                8'h18: st_reg <= vx;
                                8'h1E: i_reg <= i_reg + {8'd0, vx};
                                8'h33: begin
                                    bcd_reg   <= vx;
                                    state_reg <= ST_BCD;
                                end
                                8'h55: state_reg <= ST_STORE;
                                8'h65: state_reg <= ST_LOAD;
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                ST_BCD: begin
                    // digit position 0: hundreds, 1: tens, 2: ones
                    if (cnt_reg != 4'd2 && !alu_sum[8]) begin
                        // keep subtracting; digit_reg counts the steps
                        bcd_reg <= alu_sum[7:0];
                    end
                    state_reg <= (cnt_reg == 4'd2) ? ST_FIN : ST_BCD;
                end
                ST_STORE: begin
                    ptr_reg <= ptr_reg + 16'd1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == op_x) state_reg <= ST_FIN;
                end
                ST_LOAD: begin
                    ptr_reg   <= ptr_reg + 16'd1;
                    state_reg <= ST_LOADW;
                end
                ST_LOADW: begin
                    v_reg[cnt_reg] <= mem_rd;
                    cnt_reg        <= cnt_reg + 4'd1;
                    state_reg      <= (cnt_reg == op_x) ? ST_FIN : ST_LOAD;
                end
                ST_FIN: begin
                    if (cmd_reg == CMD_STEP && res_reg.fault == FAULT_NONE) begin
                        pc_reg <= newpc_reg;
                        if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                        if (st_reg != 8'd0) begin
                            st_reg <= st_reg - 8'd1;
                        end
                        res_reg.pc           <= newpc_reg;
                        res_reg.sound_active <= (st_reg > 8'd1);
                    end else begin
                        res_reg.pc           <= pc_reg;
                        res_reg.sound_active <= (st_reg != 8'd0);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            // BCD digit writes advance the position once a digit completes
            if (state_reg == ST_BCD && (cnt_reg == 4'd2 || alu_sum[8])) begin
                cnt_reg <= cnt_reg + 4'd1;
                ptr_reg <= ptr_reg + 16'd1;
            end
        end
    end

    // digit accumulator: counts subtractions for the current BCD digit
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) digit_reg <= 8'd0;
        else if (state_reg == ST_BCD) begin
            if (alu_sum[8]) digit_reg <= 8'd0;
            else digit_reg <= digit_reg + 8'd1;
        end
    end
endmodule
`default_nettype wire
